@@ design/hmmd_pkg.sv @@
// Package for the handheld memory-map decoder.
// Holds target codes, region boundaries, RAM depths and the decode result struct.
// No dependencies.
package hmmd_pkg;

  localparam int unsigned WORK_RAM_DEPTH  = 8192;
  localparam int unsigned EXT_RAM_DEPTH   = 8192;
  localparam int unsigned ZERO_PAGE_DEPTH = 128;

  localparam int unsigned ADDR_W = 16;
  localparam int unsigned DATA_W = 8;

  // Bus access kinds
  typedef enum logic {
    OP_READ  = 1'b0,
    OP_WRITE = 1'b1
  } op_e;

  // Decoded target of one access
  typedef enum logic [2:0] {
    TGT_NONE = 3'd0,
    TGT_BIOS = 3'd1,
    TGT_ROM  = 3'd2,
    TGT_VRAM = 3'd3,
    TGT_ERAM = 3'd4,
    TGT_WRAM = 3'd5,
    TGT_ZRAM = 3'd6,
    TGT_GPU  = 3'd7
  } tgt_e;

  // Region boundaries
  localparam logic [ADDR_W-1:0] BIOS_END   = 16'h0100;
  localparam logic [ADDR_W-1:0] BOOT_PC    = 16'h0100;
  localparam logic [ADDR_W-1:0] OAM_BASE   = 16'hFE00;
  localparam logic [ADDR_W-1:0] IO_BASE    = 16'hFF00;
  localparam logic [ADDR_W-1:0] GPU_BASE   = 16'hFF40;
  localparam logic [ADDR_W-1:0] ZPAGE_BASE = 16'hFF80;

  // Decode outcome for one access
  typedef struct packed {
    tgt_e              target;
    logic [ADDR_W-1:0] fwd_addr;
    logic              fwd_write;
    logic              boot_next;
    logic              eram_we;
    logic              wram_we;
    logic              zram_we;
    logic              ram_read;  // read of one of the internal RAMs
  } dec_t;

endpackage

@@ design/hmmd_ram.sv @@
// Single-port-write, single-port-read byte RAM with registered read data.
// Depends on hmmd_pkg for the data width.
module hmmd_ram #(
  parameter int unsigned Depth = hmmd_pkg::WORK_RAM_DEPTH,
  localparam int unsigned AW   = $clog2(Depth)
) (
  input  logic                        clk_i,
  input  logic                        we_i,
  input  logic [AW-1:0]               waddr_i,
  input  logic [hmmd_pkg::DATA_W-1:0] wdata_i,
  input  logic [AW-1:0]               raddr_i,
  output logic [hmmd_pkg::DATA_W-1:0] rdata_o
);

  logic [hmmd_pkg::DATA_W-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem[raddr_i];
  end

endmodule

@@ design/hmmd_decode.sv @@
// Address decoder: maps one byte access onto its target and the boot-flag update.
// Depends on hmmd_pkg for target codes, region bounds and dec_t.
module hmmd_decode (
  input  logic                        valid_i,
  input  logic                        op_i,
  input  logic [hmmd_pkg::ADDR_W-1:0] addr_i,
  input  logic [hmmd_pkg::ADDR_W-1:0] pc_i,
  input  logic                        in_boot_i,
  output hmmd_pkg::dec_t              dec_o
);

  logic       wr;
  logic [3:0] region;

  assign wr     = (op_i == hmmd_pkg::OP_WRITE);
  assign region = addr_i[15:12];

  always_comb begin
    dec_o           = '0;
    dec_o.target    = hmmd_pkg::TGT_NONE;
    dec_o.boot_next = in_boot_i;

    if (region inside {[4'h0:4'h7]}) begin
      if (!wr) begin
        if (region == 4'h0 && in_boot_i && addr_i < hmmd_pkg::BIOS_END) begin
          dec_o.target = hmmd_pkg::TGT_BIOS;
        end else begin
          // boot program hands over: leave the overlay
          if (region == 4'h0 && in_boot_i && pc_i == hmmd_pkg::BOOT_PC) begin
            dec_o.boot_next = 1'b0;
          end
          dec_o.target = hmmd_pkg::TGT_ROM;
        end
        dec_o.fwd_addr = addr_i;
      end
    end else if (region inside {4'h8, 4'h9}) begin
      if (wr) begin
        dec_o.target    = hmmd_pkg::TGT_VRAM;
        dec_o.fwd_addr  = addr_i;
        dec_o.fwd_write = 1'b1;
      end
    end else if (region inside {4'hA, 4'hB}) begin
      dec_o.target   = hmmd_pkg::TGT_ERAM;
      dec_o.eram_we  = wr;
      dec_o.ram_read = !wr;
    end else if (addr_i < hmmd_pkg::OAM_BASE) begin
      dec_o.target   = hmmd_pkg::TGT_WRAM;
      dec_o.wram_we  = wr;
      dec_o.ram_read = !wr;
    end else if (addr_i < hmmd_pkg::IO_BASE) begin
      // OAM and unused area: nothing
    end else if (addr_i >= hmmd_pkg::ZPAGE_BASE) begin
      dec_o.target   = hmmd_pkg::TGT_ZRAM;
      dec_o.zram_we  = wr;
      dec_o.ram_read = !wr;
    end else if (addr_i >= hmmd_pkg::GPU_BASE) begin
      dec_o.target    = hmmd_pkg::TGT_GPU;
      dec_o.fwd_addr  = addr_i;
      dec_o.fwd_write = wr;
    end

    // no side effects without a live item
    if (!valid_i) begin
      dec_o.boot_next = in_boot_i;
      dec_o.eram_we   = 1'b0;
      dec_o.wram_we   = 1'b0;
      dec_o.zram_we   = 1'b0;
    end
  end

endmodule

@@ design/handheld_memory_map_decoder.sv @@
// Top level of the handheld memory-map decoder.
// Depends on hmmd_pkg, hmmd_decode and hmmd_ram.
//
// Usage:
//   Command channel: an access (operation_i, address_i, write_data_i, cpu_pc_i)
//   is a transfer at a rising edge with start_i high and busy_o low.
//   Result channel: done_o is high for exactly one cycle with read_data_o,
//   target_o, forward_address_o, forward_write_o and boot_overlay_o valid;
//   the receiver takes the transfer at the end of that cycle and cannot stall.
//   Path: the input register, then decode, then the result register; the
//   RAM read data is registered alongside the result register.
//   Throughput: one access per cycle; busy_o is low whenever the clear
//   sweep is finished, so back-to-back commands are taken every cycle.
//   The rate is set by the single registered read port of each RAM.
//   Reset: in_boot returns to 1 and a clear sweep writes zero into every
//   RAM entry, one address per cycle across all three RAMs in parallel,
//   over the addresses of the deepest RAM, max(WORK_RAM_DEPTH, EXT_RAM_DEPTH,
//   ZERO_PAGE_DEPTH) (8192 entries with default depths). busy_o is high for the whole sweep.
//   A write followed immediately by a read of the same byte returns the new
//   value: the write lands at the edge before the read samples the array.
module handheld_memory_map_decoder #(
  parameter int unsigned WORK_RAM_DEPTH  = hmmd_pkg::WORK_RAM_DEPTH,
  parameter int unsigned EXT_RAM_DEPTH   = hmmd_pkg::EXT_RAM_DEPTH,
  parameter int unsigned ZERO_PAGE_DEPTH = hmmd_pkg::ZERO_PAGE_DEPTH
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        operation_i,
  input  logic [hmmd_pkg::ADDR_W-1:0] address_i,
  input  logic [hmmd_pkg::DATA_W-1:0] write_data_i,
  input  logic [hmmd_pkg::ADDR_W-1:0] cpu_pc_i,
  output logic                        done_o,
  output logic [hmmd_pkg::DATA_W-1:0] read_data_o,
  output logic [2:0]                  target_o,
  output logic [hmmd_pkg::ADDR_W-1:0] forward_address_o,
  output logic                        forward_write_o,
  output logic                        boot_overlay_o
);

  localparam int unsigned WAW = $clog2(WORK_RAM_DEPTH);
  localparam int unsigned EAW = $clog2(EXT_RAM_DEPTH);
  localparam int unsigned ZAW = $clog2(ZERO_PAGE_DEPTH);
  // sweep length covers the deepest RAM
  localparam int unsigned CLR_DEPTH =
    (WORK_RAM_DEPTH > EXT_RAM_DEPTH)
      ? ((WORK_RAM_DEPTH > ZERO_PAGE_DEPTH) ? WORK_RAM_DEPTH : ZERO_PAGE_DEPTH)
      : ((EXT_RAM_DEPTH > ZERO_PAGE_DEPTH) ? EXT_RAM_DEPTH : ZERO_PAGE_DEPTH);
  localparam int unsigned CAW = $clog2(CLR_DEPTH);
  localparam logic [CAW-1:0] CLR_LAST = CAW'(CLR_DEPTH - 1);

  // ---------------------------------------------------------------------------
  // Clear sweep after reset
  // ---------------------------------------------------------------------------
  logic           clearing_q, clearing_d;
  logic [CAW-1:0] clr_cnt_q, clr_cnt_d;

  always_comb begin
    clearing_d = clearing_q;
    clr_cnt_d  = clr_cnt_q;
    if (clearing_q) begin
      clr_cnt_d = clr_cnt_q + CAW'(1);
      if (clr_cnt_q == CLR_LAST) begin
        clearing_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else begin
      clearing_q <= clearing_d;
      clr_cnt_q  <= clr_cnt_d;
    end
  end

  assign busy_o = clearing_q;

  // ---------------------------------------------------------------------------
  // Input register
  // ---------------------------------------------------------------------------
  logic                        accept;
  logic                        s1_valid_q;
  logic                        s1_op_q;
  logic [hmmd_pkg::ADDR_W-1:0] s1_addr_q;
  logic [hmmd_pkg::DATA_W-1:0] s1_data_q;
  logic [hmmd_pkg::ADDR_W-1:0] s1_pc_q;

  assign accept = start_i && !busy_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_op_q   <= operation_i;
      s1_addr_q <= address_i;
      s1_data_q <= write_data_i;
      s1_pc_q   <= cpu_pc_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Decode
  // ---------------------------------------------------------------------------
  logic           in_boot_q;
  hmmd_pkg::dec_t dec;

  hmmd_decode u_decode (
    .valid_i   (s1_valid_q),
    .op_i      (s1_op_q),
    .addr_i    (s1_addr_q),
    .pc_i      (s1_pc_q),
    .in_boot_i (in_boot_q),
    .dec_o     (dec)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_boot_q <= 1'b1;
    end else begin
      in_boot_q <= dec.boot_next;
    end
  end

  // ---------------------------------------------------------------------------
  // Internal RAMs: the sweep owns the write ports while clearing
  // ---------------------------------------------------------------------------
  logic [hmmd_pkg::DATA_W-1:0] wdata;
  logic [hmmd_pkg::DATA_W-1:0] wram_rdata, eram_rdata, zram_rdata;

  assign wdata = clearing_q ? '0 : s1_data_q;

  hmmd_ram #(.Depth(WORK_RAM_DEPTH)) u_wram (
    .clk_i   (clk_i),
    .we_i    (clearing_q || dec.wram_we),
    .waddr_i (clearing_q ? clr_cnt_q[WAW-1:0] : s1_addr_q[WAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (s1_addr_q[WAW-1:0]),
    .rdata_o (wram_rdata)
  );

  hmmd_ram #(.Depth(EXT_RAM_DEPTH)) u_eram (
    .clk_i   (clk_i),
    .we_i    (clearing_q || dec.eram_we),
    .waddr_i (clearing_q ? clr_cnt_q[EAW-1:0] : s1_addr_q[EAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (s1_addr_q[EAW-1:0]),
    .rdata_o (eram_rdata)
  );

  hmmd_ram #(.Depth(ZERO_PAGE_DEPTH)) u_zram (
    .clk_i   (clk_i),
    .we_i    (clearing_q || dec.zram_we),
    .waddr_i (clearing_q ? clr_cnt_q[ZAW-1:0] : s1_addr_q[ZAW-1:0]),
    .wdata_i (wdata),
    .raddr_i (s1_addr_q[ZAW-1:0]),
    .rdata_o (zram_rdata)
  );

  // ---------------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------------
  logic                        done_q;
  hmmd_pkg::tgt_e              tgt_q;
  logic [hmmd_pkg::ADDR_W-1:0] fwd_addr_q;
  logic                        fwd_write_q;
  logic                        boot_q;
  logic                        ram_read_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q) begin
      tgt_q       <= dec.target;
      fwd_addr_q  <= dec.fwd_addr;
      fwd_write_q <= dec.fwd_write;
      boot_q      <= dec.boot_next;
      ram_read_q  <= dec.ram_read;
    end
  end

  // RAM read data arrives registered alongside the result fields
  always_comb begin
    read_data_o = '0;
    if (ram_read_q) begin
      case (tgt_q)
        hmmd_pkg::TGT_ERAM: read_data_o = eram_rdata;
        hmmd_pkg::TGT_WRAM: read_data_o = wram_rdata;
        hmmd_pkg::TGT_ZRAM: read_data_o = zram_rdata;
        default:            read_data_o = '0;
      endcase
    end
  end

  assign done_o            = done_q;
  assign target_o          = tgt_q;
  assign forward_address_o = fwd_addr_q;
  assign forward_write_o   = fwd_write_q;
  assign boot_overlay_o    = boot_q;

endmodule

@@ dv/tb_handheld_memory_map_decoder.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for handheld_memory_map_decoder: directed and random byte accesses.
// A local decode model predicts each result. Depends on hmmd_pkg and the design top level.
module tb_handheld_memory_map_decoder;

  // Region bases that the package does not name
  localparam logic [hmmd_pkg::ADDR_W-1:0] VRAM_BASE   = 16'h8000;
  localparam logic [hmmd_pkg::ADDR_W-1:0] ERAM_BASE   = 16'hA000;
  localparam logic [hmmd_pkg::ADDR_W-1:0] WRAM_BASE   = 16'hC000;
  localparam logic [hmmd_pkg::ADDR_W-1:0] MIRROR_BASE = 16'hE000;

  localparam int unsigned CYCLE_LIMIT  = 200000;  // clear sweep plus ~400 paced items, many times over
  localparam int unsigned DRAIN_CYCLES = 8;       // covers the input and result registers, with margin
  localparam int unsigned RESET_CYCLES = 8;

  // One expected result on the done_o strobe
  typedef struct packed {
    logic [hmmd_pkg::DATA_W-1:0] rd;
    hmmd_pkg::tgt_e              tgt;
    logic [hmmd_pkg::ADDR_W-1:0] fa;
    logic                        fw;
    logic                        boot;
  } access_result_t;

  logic                        clk_i;
  logic                        rst_ni;
  logic                        start_i;
  logic                        busy_o;
  logic                        operation_i;
  logic [hmmd_pkg::ADDR_W-1:0] address_i;
  logic [hmmd_pkg::DATA_W-1:0] write_data_i;
  logic [hmmd_pkg::ADDR_W-1:0] cpu_pc_i;
  logic                        done_o;
  logic [hmmd_pkg::DATA_W-1:0] read_data_o;
  logic [2:0]                  target_o;
  logic [hmmd_pkg::ADDR_W-1:0] forward_address_o;
  logic                        forward_write_o;
  logic                        boot_overlay_o;

  // Shadow copy of the decoder's state
  logic                        boot_flag;
  logic [hmmd_pkg::DATA_W-1:0] wram_shadow [hmmd_pkg::WORK_RAM_DEPTH];
  logic [hmmd_pkg::DATA_W-1:0] eram_shadow [hmmd_pkg::EXT_RAM_DEPTH];
  logic [hmmd_pkg::DATA_W-1:0] zram_shadow [hmmd_pkg::ZERO_PAGE_DEPTH];

  access_result_t pending_results[$];
  int unsigned    errors = 0;
  int unsigned    cycles = 0;
  int unsigned    burst_left;  // transfers left before the sender pauses
  bit             cmd_raised;  // mirrors start_i as last driven

  handheld_memory_map_decoder uut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start_i           (start_i),
    .busy_o            (busy_o),
    .operation_i       (operation_i),
    .address_i         (address_i),
    .write_data_i      (write_data_i),
    .cpu_pc_i          (cpu_pc_i),
    .done_o            (done_o),
    .read_data_o       (read_data_o),
    .target_o          (target_o),
    .forward_address_o (forward_address_o),
    .forward_write_o   (forward_write_o),
    .boot_overlay_o    (boot_overlay_o)
  );

  always begin
    clk_i = 1'b1;
    #1;
    clk_i = 1'b0;
    #1;
  end

  // Watchdog: also covers the clear sweep after reset
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic report_mismatch(input string what,
                                 input logic [hmmd_pkg::ADDR_W-1:0] got,
                                 input logic [hmmd_pkg::ADDR_W-1:0] exp);
    $display("[%0t] MISMATCH %s: got %h, expected %h", $realtime, what, got, exp);
    errors++;
  endtask

  // Decode one access against the shadow state, updating it as the block would.
  function automatic access_result_t decode_access(hmmd_pkg::op_e op,
                                                   logic [hmmd_pkg::ADDR_W-1:0] a,
                                                   logic [hmmd_pkg::DATA_W-1:0] d,
                                                   logic [hmmd_pkg::ADDR_W-1:0] pc);
    access_result_t r;
    r = '{rd: '0, tgt: hmmd_pkg::TGT_NONE, fa: '0, fw: 1'b0, boot: 1'b0};
    if (a < VRAM_BASE) begin
      // ROM space; writes are dropped and never touch the boot flag
      if (op == hmmd_pkg::OP_READ) begin
        if (a[15:12] == 4'h0 && boot_flag && a < hmmd_pkg::BIOS_END) begin
          r.tgt = hmmd_pkg::TGT_BIOS;
        end else begin
          // boot hand-over: read in the low 4 KiB above the BIOS with PC at entry
          if (a[15:12] == 4'h0 && boot_flag && pc == hmmd_pkg::BOOT_PC) boot_flag = 1'b0;
          r.tgt = hmmd_pkg::TGT_ROM;
        end
        r.fa = a;
      end
    end else if (a < ERAM_BASE) begin
      // VRAM: only writes are forwarded, reads give zero and no target
      if (op == hmmd_pkg::OP_WRITE) begin
        r.tgt = hmmd_pkg::TGT_VRAM;
        r.fa  = a;
        r.fw  = 1'b1;
      end
    end else if (a < WRAM_BASE) begin
      r.tgt = hmmd_pkg::TGT_ERAM;
      if (op == hmmd_pkg::OP_WRITE) eram_shadow[a[12:0]] = d;
      else r.rd = eram_shadow[a[12:0]];
    end else if (a < hmmd_pkg::OAM_BASE) begin
      // work RAM and its mirror share the low 13 bits
      r.tgt = hmmd_pkg::TGT_WRAM;
      if (op == hmmd_pkg::OP_WRITE) wram_shadow[a[12:0]] = d;
      else r.rd = wram_shadow[a[12:0]];
    end else if (a < hmmd_pkg::IO_BASE) begin
      // OAM and unused area: nothing happens
    end else if (a >= hmmd_pkg::ZPAGE_BASE) begin
      r.tgt = hmmd_pkg::TGT_ZRAM;
      if (op == hmmd_pkg::OP_WRITE) zram_shadow[a[6:0]] = d;
      else r.rd = zram_shadow[a[6:0]];
    end else if (a >= hmmd_pkg::GPU_BASE) begin
      r.tgt = hmmd_pkg::TGT_GPU;
      r.fa  = a;
      r.fw  = (op == hmmd_pkg::OP_WRITE);
    end
    // plain I/O below the GPU registers falls through as target none
    r.boot = boot_flag;
    return r;
  endfunction

  // Issue one access, wait for the transfer, record the prediction, then pace the sender.
  // Called just after a rising edge; returns just after the edge that took the transfer, or after the pause.
  task automatic send_access(input hmmd_pkg::op_e op, input logic [hmmd_pkg::ADDR_W-1:0] a,
                             input logic [hmmd_pkg::DATA_W-1:0] d,
                             input logic [hmmd_pkg::ADDR_W-1:0] pc);
    bit taken;
    int unsigned gap;
    start_i      <= 1'b1;
    operation_i  <= op;
    address_i    <= a;
    write_data_i <= d;
    cpu_pc_i     <= pc;
    cmd_raised    = 1'b1;
    taken         = 1'b0;
    while (!taken) begin
      @(posedge clk_i);
      taken = !busy_o;
    end
    pending_results.push_back(decode_access(op, a, d, pc));
    if (burst_left == 0) begin
      // bursts of random length, sometimes long stretches without a pause
      start_i   <= 1'b0;
      cmd_raised = 1'b0;
      gap        = $urandom_range(1, 6);
      repeat (gap) @(posedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(0, 5);
    end else begin
      burst_left--;
    end
  endtask

  // Random accesses weighted toward the RAMs so that reads find bytes written earlier
  task automatic run_random(input int unsigned count, input bit keep_boot);
    hmmd_pkg::op_e               op;
    logic [hmmd_pkg::ADDR_W-1:0] a;
    logic [hmmd_pkg::ADDR_W-1:0] pc;
    logic [12:0]                 off;
    int unsigned                 kind;
    repeat (count) begin
      op = ($urandom_range(0, 1) == 1) ? hmmd_pkg::OP_WRITE : hmmd_pkg::OP_READ;
      // half the RAM offsets come from a small pool at both ends of the array
      if ($urandom_range(0, 1) == 1)
        off = (($urandom_range(0, 1) == 1) ? 13'h1FF0 : 13'h0000) | 13'($urandom_range(0, 15));
      else
        off = 13'($urandom_range(0, 8191));
      kind = $urandom_range(0, 11);
      case (kind)
        0: begin
          a = 16'($urandom_range(0, 16'h7FFF));
        end
        1: begin
          a = 16'($urandom_range(0, 16'h0FFF));
        end
        2: begin
          a = 16'($urandom_range(16'h8000, 16'h9FFF));
        end
        3, 4: begin
          a = ERAM_BASE | 16'(off);
        end
        5, 6: begin
          if ($urandom_range(0, 1) == 1 && off < 13'h1E00) a = MIRROR_BASE + 16'(off);
          else a = WRAM_BASE | 16'(off);
        end
        7: begin
          a = 16'($urandom_range(16'hFE00, 16'hFEFF));
        end
        8: begin
          a = 16'($urandom_range(16'hFF00, 16'hFF7F));
        end
        9, 10: begin
          a = hmmd_pkg::ZPAGE_BASE | 16'(($urandom_range(0, 1) == 1) ? $urandom_range(0, 7)
                                                                     : $urandom_range(0, 127));
        end
        default: begin
          a = 16'($urandom_range(0, 16'hFFFF));
        end
      endcase
      pc = ($urandom_range(0, 7) == 0) ? hmmd_pkg::BOOT_PC : 16'($urandom_range(0, 16'hFFFF));
      // hold the overlay on until the hand-over test
      if (keep_boot && pc == hmmd_pkg::BOOT_PC && op == hmmd_pkg::OP_READ &&
          a[15:12] == 4'h0 && a >= hmmd_pkg::BIOS_END)
        pc = hmmd_pkg::BOOT_PC + 16'd1;
      send_access(op, a, 8'($urandom_range(0, 255)), pc);
    end
  endtask

  // Region edges and the special cases, all with the boot overlay still on
  task automatic test_directed_regions();
    send_access(hmmd_pkg::OP_READ,  16'h0000, 8'h00, 16'h0000);          // BIOS
    send_access(hmmd_pkg::OP_READ,  16'h00FF, 8'hFF, hmmd_pkg::BOOT_PC); // BIOS even with PC at entry
    send_access(hmmd_pkg::OP_WRITE, 16'h0000, 8'hFF, hmmd_pkg::BOOT_PC); // ROM write dropped
    send_access(hmmd_pkg::OP_READ,  16'h7FFF, 8'h00, 16'hFFFF);          // ROM top
    send_access(hmmd_pkg::OP_WRITE, 16'h8000, 8'hA5, 16'h0000);          // VRAM write forwarded
    send_access(hmmd_pkg::OP_READ,  16'h9FFF, 8'h00, 16'h0000);          // VRAM read gives nothing
    send_access(hmmd_pkg::OP_WRITE, 16'hA000, 8'hFF, 16'h0000);
    send_access(hmmd_pkg::OP_READ,  16'hA000, 8'h00, 16'h0000);  // read after write of the same byte
    send_access(hmmd_pkg::OP_WRITE, 16'hBFFF, 8'h5A, 16'h0000);
    send_access(hmmd_pkg::OP_READ,  16'hBFFF, 8'h00, 16'h0000);
    send_access(hmmd_pkg::OP_WRITE, 16'hC000, 8'h3C, 16'h0000);
    send_access(hmmd_pkg::OP_READ,  16'hE000, 8'h00, 16'h0000);  // mirror of work RAM
    send_access(hmmd_pkg::OP_WRITE, 16'hFDFF, 8'hC3, 16'h0000);  // mirror top
    send_access(hmmd_pkg::OP_READ,  16'hDDFF, 8'h00, 16'h0000);
    send_access(hmmd_pkg::OP_READ,  16'hDFFF, 8'h00, 16'h0000);  // never written, still zero
    send_access(hmmd_pkg::OP_WRITE, 16'hFE00, 8'hFF, 16'h0000);  // OAM write dropped
    send_access(hmmd_pkg::OP_READ,  16'hFEFF, 8'h00, 16'h0000);
    send_access(hmmd_pkg::OP_WRITE, 16'hFF00, 8'hFF, 16'h0000);  // plain I/O dropped
    send_access(hmmd_pkg::OP_READ,  16'hFF3F, 8'h00, 16'h0000);
    send_access(hmmd_pkg::OP_WRITE, 16'hFF40, 8'h81, 16'h0000);  // GPU register write
    send_access(hmmd_pkg::OP_READ,  16'hFF7F, 8'h00, 16'h0000);  // GPU register read
    send_access(hmmd_pkg::OP_WRITE, 16'hFF80, 8'h55, 16'h0000);
    send_access(hmmd_pkg::OP_WRITE, 16'hFFFF, 8'hAA, 16'h0000);
    send_access(hmmd_pkg::OP_READ,  16'hFF80, 8'h00, 16'h0000);
    send_access(hmmd_pkg::OP_READ,  16'hFFFF, 8'h00, 16'h0000);
  endtask

  task automatic test_random_in_boot();
    run_random(150, 1'b1);
  endtask

  // Near misses first, then the hand-over read and BIOS-range reads afterwards
  task automatic test_boot_exit();
    send_access(hmmd_pkg::OP_READ,  16'h0100, 8'h00, 16'h0101);          // wrong PC
    send_access(hmmd_pkg::OP_WRITE, 16'h0100, 8'h00, hmmd_pkg::BOOT_PC); // write never hands over
    send_access(hmmd_pkg::OP_READ,  16'h1000, 8'h00, hmmd_pkg::BOOT_PC); // outside the low 4 KiB
    send_access(hmmd_pkg::OP_READ,  16'h0FFF, 8'h00, hmmd_pkg::BOOT_PC); // hand-over
    send_access(hmmd_pkg::OP_READ,  16'h0000, 8'h00, 16'h0000);          // now ROM
    send_access(hmmd_pkg::OP_READ,  16'h00FF, 8'h00, hmmd_pkg::BOOT_PC);
  endtask

  task automatic test_random_after_boot();
    run_random(250, 1'b0);
  endtask

  // Each strobe is compared with the oldest prediction
  always @(posedge clk_i) begin
    access_result_t exp_r;
    if (rst_ni && done_o === 1'b1) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending, target", 16'(target_o), '0);
      end else begin
        exp_r = pending_results.pop_front();
        if (read_data_o !== exp_r.rd)
          report_mismatch("read_data", 16'(read_data_o), 16'(exp_r.rd));
        if (target_o !== exp_r.tgt)
          report_mismatch("target", 16'(target_o), 16'(exp_r.tgt));
        if (forward_address_o !== exp_r.fa)
          report_mismatch("forward_address", forward_address_o, exp_r.fa);
        if (forward_write_o !== exp_r.fw)
          report_mismatch("forward_write", 16'(forward_write_o), 16'(exp_r.fw));
        if (boot_overlay_o !== exp_r.boot)
          report_mismatch("boot_overlay", 16'(boot_overlay_o), 16'(exp_r.boot));
      end
    end
  end

  initial begin
    cmd_raised   = 1'b0;
    burst_left   = $urandom_range(0, 5);
    boot_flag    = 1'b1;
    foreach (wram_shadow[i]) wram_shadow[i] = '0;
    foreach (eram_shadow[i]) eram_shadow[i] = '0;
    foreach (zram_shadow[i]) zram_shadow[i] = '0;
    rst_ni       = 1'b0;
    start_i      = 1'b0;
    operation_i  = hmmd_pkg::OP_READ;
    address_i    = '0;
    write_data_i = '0;
    cpu_pc_i     = '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // send_access waits out the clear sweep through busy_o
    test_directed_regions();
    test_random_in_boot();
    test_boot_exit();
    test_random_after_boot();

    if (cmd_raised) start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
